/* rtl/core/pmtud_pkg.sv */
// Shared types, constants and the plateau table for the path MTU tracker.
// No dependencies.
`timescale 1ns / 1ps

package pmtud_pkg;

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_SENT  = 2'd1,
    OP_ACK   = 2'd2,
    OP_FRAG  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_OVERRIDE = 3'd0,
    REG_HEADER   = 3'd1,
    REG_RETRY    = 3'd2,
    REG_REPROBE  = 3'd3,
    REG_EXPIRY   = 3'd4
  } reg_idx_t;

  localparam int MAX_PLATEAUS = 16;
  localparam logic [15:0] START_MTU = 16'd1300;

  // Commands travelling down the cell row.
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_CLEAR = 2'd1,   // clear all entries with seq <= key
    CMD_WRITE = 2'd2    // write key/size/time into the selected cell
  } cmd_t;

  // Per-cell status gathered by the controller.
  typedef struct packed {
    logic        valid;
    logic [31:0] seq;
    logic [15:0] size;
    logic [31:0] stamp;
  } cell_status_t;

  function automatic logic [15:0] plateau(input logic [3:0] i);
    case (i)
      4'd0:  plateau = 16'd68;
      4'd1:  plateau = 16'd296;
      4'd2:  plateau = 16'd508;
      4'd3:  plateau = 16'd576;
      4'd4:  plateau = 16'd1006;
      4'd5:  plateau = 16'd1492;
      4'd6:  plateau = 16'd2002;
      4'd7:  plateau = 16'd4352;
      4'd8:  plateau = 16'd8166;
      4'd9:  plateau = 16'd17914;
      4'd10: plateau = 16'd32000;
      default: plateau = 16'd65535;
    endcase
  endfunction

endpackage

/* rtl/core/pmtud_cell.sv */
// One probe table entry of the path MTU tracker.
// Depends on pmtud_pkg.
`timescale 1ns / 1ps

module pmtud_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  pmtud_pkg::cmd_t         cmd,
  input  logic                    sel,
  input  logic [31:0]             key,
  input  logic [15:0]             wr_size,
  input  logic [31:0]             wr_stamp,
  output pmtud_pkg::cell_status_t status
);

  logic        valid;
  logic [31:0] seq;
  logic [15:0] size;
  logic [31:0] stamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (cmd)
        pmtud_pkg::CMD_CLEAR: if (valid && seq <= key) valid <= 1'b0;
        pmtud_pkg::CMD_WRITE: if (sel) valid <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == pmtud_pkg::CMD_WRITE && sel) begin
      seq   <= key;
      size  <= wr_size;
      stamp <= wr_stamp;
    end
  end

  assign status = '{valid: valid, seq: seq, size: size, stamp: stamp};

endmodule

/* rtl/core/pmtud_row.sv */
// Row of probe cells with a lowest-sequence chain through the row.
// Depends on pmtud_pkg and pmtud_cell.
`timescale 1ns / 1ps

module pmtud_row #(
  parameter int SLOTS = 8,
  parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  pmtud_pkg::cmd_t   cmd,
  input  logic [IW-1:0]     wr_idx,
  input  logic [31:0]       key,
  input  logic [15:0]       wr_size,
  input  logic [31:0]       wr_stamp,
  output pmtud_pkg::cell_status_t st [SLOTS],
  // Registered summaries, valid in the cycle after the row settles.
  output logic              any_valid,
  output logic              lo_found,
  output logic [IW-1:0]     lo_idx,
  output logic              match_found,
  output logic [IW-1:0]     match_idx,
  output logic              free_found,
  output logic [IW-1:0]     free_idx
);

  // Chain signals handed from cell to cell.
  logic          c_lo_f   [SLOTS+1];
  logic [IW-1:0] c_lo_i   [SLOTS+1];
  logic [31:0]   c_lo_s   [SLOTS+1];
  logic          c_m_f    [SLOTS+1];
  logic [IW-1:0] c_m_i    [SLOTS+1];
  logic          c_f_f    [SLOTS+1];
  logic [IW-1:0] c_f_i    [SLOTS+1];
  logic          c_any    [SLOTS+1];

  assign c_lo_f[0] = 1'b0;
  assign c_lo_i[0] = '0;
  assign c_lo_s[0] = '0;
  assign c_m_f[0]  = 1'b0;
  assign c_m_i[0]  = '0;
  assign c_f_f[0]  = 1'b0;
  assign c_f_i[0]  = '0;
  assign c_any[0]  = 1'b0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    logic take_lo;
    pmtud_cell u_cell (
      .clk(clk), .rst(rst), .cmd(cmd),
      .sel(wr_idx == IW'(g)), .key(key),
      .wr_size(wr_size), .wr_stamp(wr_stamp), .status(st[g])
    );
    assign take_lo = st[g].valid && (!c_lo_f[g] || st[g].seq < c_lo_s[g]);
    assign c_lo_f[g+1] = c_lo_f[g] || st[g].valid;
    assign c_lo_i[g+1] = take_lo ? IW'(g) : c_lo_i[g];
    assign c_lo_s[g+1] = take_lo ? st[g].seq : c_lo_s[g];
    assign c_m_f[g+1]  = c_m_f[g] || (st[g].valid && st[g].seq == key);
    assign c_m_i[g+1]  = (!c_m_f[g] && st[g].valid && st[g].seq == key) ? IW'(g) : c_m_i[g];
    assign c_f_f[g+1]  = c_f_f[g] || !st[g].valid;
    assign c_f_i[g+1]  = (!c_f_f[g] && !st[g].valid) ? IW'(g) : c_f_i[g];
    assign c_any[g+1]  = c_any[g] || st[g].valid;
  end

  always_ff @(posedge clk) begin
    any_valid   <= c_any[SLOTS];
    lo_found    <= c_lo_f[SLOTS];
    lo_idx      <= c_lo_i[SLOTS];
    match_found <= c_m_f[SLOTS];
    match_idx   <= c_m_i[SLOTS];
    free_found  <= c_f_f[SLOTS];
    free_idx    <= c_f_i[SLOTS];
  end

endmodule

/* rtl/core/path_mtu_discovery_top.sv */
// Top level of the path MTU tracker: handshakes, registers, sequencer.
// Depends on pmtud_pkg and pmtud_row.
//
//  channel  | dir | beat contents
//  s_axis   | in  | tdata: op, now_ms, seq, payload_bytes ; tuser: acked
//  m_axis   | out | tdata: max_payload, path_mtu, probe_offered, probe_dropped
//  apb      | in  | five registers at byte addresses 0,4,8,12,16
//
// Query, ack and fragmentation beats pass S_WAIT, S_DECIDE, S_OUT before
// the next ready; sent beats add S_EXP_WAIT, S_EXP_SETTLE, S_EXP_CHK per
// expired probe plus once. The row summary register sets the pace.
// Reset is synchronous and empties the probe table at once.
// A result waiting in the output register holds the next beat in its
// output state only.
`timescale 1ns / 1ps

module path_mtu_discovery_top #(
  parameter int PROBE_SLOTS   = 8,
  parameter int PLATEAU_COUNT = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // op[1:0] now_ms[33:2] seq[65:34] payload_bytes[81:66]
  input  logic        s_axis_tuser,  // acked
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // max_payload, path_mtu, probe_offered, probe_dropped
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = (PROBE_SLOTS > 1) ? $clog2(PROBE_SLOTS) : 1;
  localparam int PC = (PLATEAU_COUNT > pmtud_pkg::MAX_PLATEAUS) ? pmtud_pkg::MAX_PLATEAUS :
                      (PLATEAU_COUNT < 1) ? 1 : PLATEAU_COUNT;
  localparam logic [3:0] TOP_IDX = 4'(PC - 1);

  // Registers.
  logic [15:0] size_override;
  logic [7:0]  header_bytes;
  logic [31:0] probe_retry_ms, reprobe_ms, probe_expiry_ms;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      size_override   <= '0;
      header_bytes    <= 8'd28;
      probe_retry_ms  <= 32'd15000;
      reprobe_ms      <= 32'd600000;
      probe_expiry_ms <= 32'd1000;
    end else if (psel && penable && pwrite) begin
      case (pmtud_pkg::reg_idx_t'(paddr[4:2]))
        pmtud_pkg::REG_OVERRIDE: size_override   <= pwdata[15:0];
        pmtud_pkg::REG_HEADER:   header_bytes    <= pwdata[7:0];
        pmtud_pkg::REG_RETRY:    probe_retry_ms  <= pwdata;
        pmtud_pkg::REG_REPROBE:  reprobe_ms      <= pwdata;
        pmtud_pkg::REG_EXPIRY:   probe_expiry_ms <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (pmtud_pkg::reg_idx_t'(paddr[4:2]))
      pmtud_pkg::REG_OVERRIDE: prdata = {16'd0, size_override};
      pmtud_pkg::REG_HEADER:   prdata = {24'd0, header_bytes};
      pmtud_pkg::REG_RETRY:    prdata = probe_retry_ms;
      pmtud_pkg::REG_REPROBE:  prdata = reprobe_ms;
      pmtud_pkg::REG_EXPIRY:   prdata = probe_expiry_ms;
      default:                 prdata = '0;
    endcase
  end

  // Plateau index of the estimate: largest plateau <= estimate, clamped.
  function automatic logic [3:0] pidx(input logic [15:0] s);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < PC; i++)
      if (pmtud_pkg::plateau(4'(i)) <= s) r = 4'(i);
    return r;
  endfunction

  typedef enum logic [2:0] {
    S_IDLE, S_WAIT, S_DECIDE, S_EXP_WAIT, S_EXP_SETTLE, S_EXP_CHK, S_OUT
  } state_t;
  state_t state;

  pmtud_pkg::op_t op;
  logic [31:0] now;
  logic [15:0] payload;
  logic        acked;

  logic [15:0] mtu_estimate;
  logic        probing_wanted;
  logic [31:0] last_probe_sent_ms, last_offer_ms;
  logic [15:0] r_maxp;
  logic        r_off, r_drop;

  pmtud_pkg::cmd_t cmd;
  logic [IW-1:0]   wr_idx;
  logic [31:0]     key;
  logic [15:0]     wr_size;
  pmtud_pkg::cell_status_t st [PROBE_SLOTS];
  logic any_valid, lo_found, match_found, free_found;
  logic [IW-1:0] lo_idx, match_idx, free_idx;

  logic [16:0] sent_sum;
  logic [15:0] sz;
  assign sent_sum = {1'b0, payload} + {9'd0, header_bytes};
  assign sz = (sent_sum < 17'd65535) ? sent_sum[15:0] : 16'hFFFF;

  pmtud_row #(.SLOTS(PROBE_SLOTS), .IW(IW)) u_row (
    .clk(clk), .rst(rst), .cmd(cmd), .wr_idx(wr_idx), .key(key),
    .wr_size(wr_size), .wr_stamp(now), .st(st),
    .any_valid(any_valid), .lo_found(lo_found), .lo_idx(lo_idx),
    .match_found(match_found), .match_idx(match_idx),
    .free_found(free_found), .free_idx(free_idx)
  );

  assign s_axis_tready = (state == S_IDLE);

  // Query path values.
  logic        pw_q, offer;
  logic [15:0] report;
  logic [3:0]  up_idx, dn_idx;
  always_comb begin
    pw_q   = probing_wanted || ((now - last_probe_sent_ms) > reprobe_ms);
    offer  = pw_q && ((now - last_offer_ms) > probe_retry_ms);
    up_idx = (pidx(mtu_estimate) >= TOP_IDX) ? TOP_IDX : pidx(mtu_estimate) + 4'd1;
    report = offer ? pmtud_pkg::plateau(up_idx) : mtu_estimate;
    dn_idx = pidx(mtu_estimate);
    if (dn_idx != 4'd0 && mtu_estimate == pmtud_pkg::plateau(dn_idx)) dn_idx = dn_idx - 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd <= pmtud_pkg::CMD_NONE;
      mtu_estimate <= pmtud_pkg::START_MTU;
      probing_wanted <= 1'b1;
      last_probe_sent_ms <= '0;
      last_offer_ms <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      cmd <= pmtud_pkg::CMD_NONE;
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (s_axis_tvalid) begin
          op      <= pmtud_pkg::op_t'(s_axis_tdata[1:0]);
          now     <= s_axis_tdata[33:2];
          key     <= s_axis_tdata[65:34];
          payload <= s_axis_tdata[81:66];
          acked   <= s_axis_tuser;
          r_maxp <= '0; r_off <= 1'b0; r_drop <= 1'b0;
          state <= S_WAIT;
        end
        S_WAIT: state <= S_DECIDE;
        S_DECIDE: begin
          state <= S_OUT;
          case (op)
            pmtud_pkg::OP_QUERY: if (size_override != 16'd0) begin
              r_maxp <= size_override;
            end else begin
              probing_wanted <= pw_q;
              r_maxp <= (report > {8'd0, header_bytes}) ? report - {8'd0, header_bytes} : '0;
              if (offer) begin
                last_offer_ms <= now;
                r_off <= 1'b1;
              end
            end
            pmtud_pkg::OP_SENT: begin
              if (sz > mtu_estimate) begin
                probing_wanted <= 1'b0;
                last_probe_sent_ms <= now;
                cmd <= pmtud_pkg::CMD_WRITE;
                wr_size <= sz;
                wr_idx <= match_found ? match_idx : free_found ? free_idx : lo_idx;
                r_drop <= !match_found && !free_found;
              end
              state <= S_EXP_WAIT;
            end
            pmtud_pkg::OP_ACK: begin
              if (acked && match_found) begin
                if (st[match_idx].size > mtu_estimate) mtu_estimate <= st[match_idx].size;
                probing_wanted <= 1'b1;
              end
              cmd <= pmtud_pkg::CMD_CLEAR;
            end
            default: if (!any_valid) begin
              mtu_estimate <= pmtud_pkg::plateau(dn_idx);
              probing_wanted <= 1'b0;
            end
          endcase
        end
        // The table command lands at the end of this cycle; the summary
        // register picks up the new table at the end of S_EXP_SETTLE.
        S_EXP_WAIT: state <= S_EXP_SETTLE;
        S_EXP_SETTLE: state <= S_EXP_CHK;
        S_EXP_CHK: begin
          if (lo_found && ((now - st[lo_idx].stamp) > probe_expiry_ms)) begin
            key <= st[lo_idx].seq;
            cmd <= pmtud_pkg::CMD_CLEAR;
            state <= S_EXP_WAIT;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata <= {6'd0, r_drop, r_off, mtu_estimate, r_maxp};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The summary registers must settle after any table command before they are read.
  a_cmd_then_wait: assert property (@(posedge clk) disable iff (rst)
    (cmd != pmtud_pkg::CMD_NONE) |-> (state == S_EXP_WAIT || state == S_OUT))
    else $error("table command issued outside a settle state");
  a_estimate_floor: assert property (@(posedge clk) disable iff (rst)
    mtu_estimate >= 16'd68)
    else $error("estimate fell below lowest plateau");
  a_offer_query: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && r_off) |-> (op == pmtud_pkg::OP_QUERY))
    else $error("probe offer flagged on non-query beat");

endmodule
